// ----- rtl/core/pgrp_pkg.sv -----
// shared types and constants for the page grouped relocation packer
package pgrp_pkg;

  localparam int unsigned MaxBytes  = 1048576;
  localparam int unsigned MaxRelocs = 262144;

  // write pointer and block size reach MaxBytes itself
  localparam int unsigned WpW  = $clog2(MaxBytes) + 1;
  localparam int unsigned OffW = 20;
  localparam int unsigned CntW = $clog2(MaxRelocs) + 1;
  localparam int unsigned ChkW = WpW + 1;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // result slots of one job, emitted lowest first
  localparam int unsigned StepPad  = 0;
  localparam int unsigned StepHdr0 = 1;
  localparam int unsigned StepHdr1 = 2;
  localparam int unsigned StepBody = 3;
  localparam int unsigned StepSize = 4;
  localparam int unsigned NSteps   = 5;

  typedef enum logic [1:0] {
    KIND_HALF  = 2'd0,
    KIND_WORD  = 2'd1,
    KIND_COUNT = 2'd2,
    KIND_SIZE  = 2'd3
  } write_kind_e;

  typedef enum logic {
    OP_ENTRY = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    logic [NSteps-1:0] mask;
    logic              flush;
    logic [OffW-1:0]   pad_off;
    logic [OffW-1:0]   blk_off;
    logic [31:0]       hdr0;
    logic [WpW-1:0]    hdr1;
    logic [OffW-1:0]   ent_off;
    logic [15:0]       ent_val;
    logic [CntW-1:0]   count;
    logic [WpW-1:0]    size;
  } job_t;

endpackage

// ----- rtl/core/pgrp_front.sv -----
// front end: accepts items, tracks blocks and capacity, builds write jobs
module pgrp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [31:0]         reloc_offset_i,
  input  logic [15:0]         type_bits_i,
  input  logic                q_full_i,
  output logic                push_o,
  output pgrp_pkg::job_t      job_o
);

  logic [31:0]                base_q;
  logic [19:0]                cur_page_q;
  logic                       seen_q;
  logic [pgrp_pkg::WpW-1:0]   blk_start_q;
  logic [pgrp_pkg::WpW-1:0]   wp_q;
  logic [pgrp_pkg::WpW-1:0]   bb_q;
  logic [pgrp_pkg::CntW-1:0]  cnt_q;

  logic                       accept;
  logic                       is_flush;
  logic [19:0]                page;
  logic                       pad;
  logic                       new_block;
  logic [pgrp_pkg::WpW-1:0]   wp_pad;
  logic [pgrp_pkg::WpW-1:0]   ent_off;
  logic [pgrp_pkg::ChkW-1:0]  chk;
  logic [pgrp_pkg::ChkW-1:0]  rounded;
  logic                       drop;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_flush   = (pgrp_pkg::op_e'(operation_i) == pgrp_pkg::OP_FLUSH);
  assign page       = reloc_offset_i[31:12];
  assign pad        = bb_q[1];
  assign new_block  = seen_q && (page != cur_page_q);
  assign wp_pad     = wp_q + (pad ? pgrp_pkg::WpW'(2) : pgrp_pkg::WpW'(0));
  assign ent_off    = new_block ? (wp_pad + pgrp_pkg::WpW'(8)) : wp_q;

  // data area size after this entry, rounded up to a word
  assign chk     = pgrp_pkg::ChkW'(ent_off) + pgrp_pkg::ChkW'(2);
  assign rounded = (chk + pgrp_pkg::ChkW'(3)) & ~pgrp_pkg::ChkW'(3);
  assign drop    = (cnt_q >= pgrp_pkg::CntW'(pgrp_pkg::MaxRelocs)) ||
                   (rounded > pgrp_pkg::ChkW'(pgrp_pkg::MaxBytes));

  assign push_o = accept && (is_flush || !drop);

  always_comb begin
    job_o         = '0;
    job_o.flush   = is_flush;
    job_o.pad_off = wp_q[pgrp_pkg::OffW-1:0];
    job_o.blk_off = blk_start_q[pgrp_pkg::OffW-1:0];
    job_o.hdr0    = {cur_page_q, 12'h000} - base_q;
    job_o.hdr1    = bb_q + (pad ? pgrp_pkg::WpW'(2) : pgrp_pkg::WpW'(0));
    job_o.ent_off = ent_off[pgrp_pkg::OffW-1:0];
    job_o.ent_val = {4'h0, reloc_offset_i[11:0]} | type_bits_i;
    job_o.count   = cnt_q;
    job_o.size    = seen_q ? wp_pad : '0;
    if (is_flush) begin
      job_o.mask[pgrp_pkg::StepSize] = 1'b1;
      if (seen_q) begin
        job_o.mask[pgrp_pkg::StepPad]  = pad;
        job_o.mask[pgrp_pkg::StepHdr0] = 1'b1;
        job_o.mask[pgrp_pkg::StepHdr1] = 1'b1;
        job_o.mask[pgrp_pkg::StepBody] = 1'b1;
      end
    end else begin
      job_o.mask[pgrp_pkg::StepBody] = 1'b1;
      if (new_block) begin
        job_o.mask[pgrp_pkg::StepPad]  = pad;
        job_o.mask[pgrp_pkg::StepHdr0] = 1'b1;
        job_o.mask[pgrp_pkg::StepHdr1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      cur_page_q  <= '0;
      seen_q      <= 1'b0;
      blk_start_q <= '0;
      wp_q        <= pgrp_pkg::WpW'(8);
      bb_q        <= pgrp_pkg::WpW'(8);
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      if (accept) begin
        if (is_flush) begin
          cur_page_q  <= '0;
          seen_q      <= 1'b0;
          blk_start_q <= '0;
          wp_q        <= pgrp_pkg::WpW'(8);
          bb_q        <= pgrp_pkg::WpW'(8);
          cnt_q       <= '0;
        end else if (!drop) begin
          seen_q     <= 1'b1;
          cur_page_q <= page;
          if (new_block) begin
            blk_start_q <= wp_pad;
            bb_q        <= pgrp_pkg::WpW'(10);
          end else begin
            bb_q <= bb_q + pgrp_pkg::WpW'(2);
          end
          wp_q  <= ent_off + pgrp_pkg::WpW'(2);
          cnt_q <= cnt_q + pgrp_pkg::CntW'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/core/pgrp_queue.sv -----
// short job queue between the front end and the write sequencer
module pgrp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pgrp_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  output pgrp_pkg::job_t head_o,
  input  logic           pop_i
);

  pgrp_pkg::job_t                slots_q [pgrp_pkg::QDepth];
  logic [pgrp_pkg::QPtrW-1:0]    wr_q;
  logic [pgrp_pkg::QPtrW-1:0]    rd_q;
  logic [pgrp_pkg::QCntW-1:0]    cnt_q;
  logic                          do_pop;

  assign full_o  = (cnt_q == pgrp_pkg::QCntW'(pgrp_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slots_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + pgrp_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + pgrp_pkg::QPtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + pgrp_pkg::QCntW'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - pgrp_pkg::QCntW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/pgrp_back.sv -----
// write sequencer: turns each job into its result beats, one per cycle while the output is not stalled
module pgrp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  pgrp_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     write_kind_o,
  output logic [19:0]    byte_offset_o,
  output logic [31:0]    write_value_o,
  output logic           last_o
);

  pgrp_pkg::job_t                 job_q;
  logic [pgrp_pkg::NSteps-1:0]    mask_q;
  logic                           out_valid_q;
  pgrp_pkg::write_kind_e          kind_q;
  logic [19:0]                    off_q;
  logic [31:0]                    val_q;
  logic                           last_q;

  logic                           advance;
  logic                           have_job;
  pgrp_pkg::job_t                 src;
  logic [pgrp_pkg::NSteps-1:0]    src_mask;
  logic [pgrp_pkg::NSteps-1:0]    low;
  logic [pgrp_pkg::NSteps-1:0]    rest;
  pgrp_pkg::write_kind_e          kind_d;
  logic [19:0]                    off_d;
  logic [31:0]                    val_d;

  assign advance  = !out_valid_q || !out_stall_i;
  assign have_job = (mask_q != '0);
  assign src      = have_job ? job_q : head_i;
  assign src_mask = have_job ? mask_q : (q_valid_i ? head_i.mask : '0);
  assign low      = src_mask & (~src_mask + pgrp_pkg::NSteps'(1));
  assign rest     = src_mask & ~low;
  assign pop_o    = advance && !have_job && q_valid_i;

  always_comb begin
    kind_d = pgrp_pkg::KIND_SIZE;
    off_d  = '0;
    val_d  = 32'(src.size);
    if (low[pgrp_pkg::StepPad]) begin
      kind_d = pgrp_pkg::KIND_HALF;
      off_d  = src.pad_off;
      val_d  = '0;
    end else if (low[pgrp_pkg::StepHdr0]) begin
      kind_d = pgrp_pkg::KIND_WORD;
      off_d  = src.blk_off;
      val_d  = src.hdr0;
    end else if (low[pgrp_pkg::StepHdr1]) begin
      kind_d = pgrp_pkg::KIND_WORD;
      off_d  = src.blk_off + 20'd4;
      val_d  = 32'(src.hdr1);
    end else if (low[pgrp_pkg::StepBody]) begin
      if (src.flush) begin
        kind_d = pgrp_pkg::KIND_COUNT;
        val_d  = 32'(src.count);
      end else begin
        kind_d = pgrp_pkg::KIND_HALF;
        off_d  = src.ent_off;
        val_d  = 32'(src.ent_val);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
    if (advance) begin
      kind_q <= kind_d;
      off_q  <= off_d;
      val_q  <= val_d;
      last_q <= (rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      mask_q      <= rest;
      out_valid_q <= (src_mask != '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign write_kind_o  = kind_q;
  assign byte_offset_o = off_q;
  assign write_value_o = val_q;
  assign last_o        = last_q;

endmodule

// ----- rtl/core/page_grouped_reloc_packer_unit.sv -----
// Relocation packer: groups sorted relocation offsets into 4 KiB page blocks
// and reports every store into the data area as a result beat. The front end
// takes one item per cycle while its two-entry job queue has room; the write
// sequencer sends one result beat per cycle while out_stall_i is low, and an
// item gives one beat per result: one for a plain entry, three or four when
// it opens a new page block, up to five for the end item. Dropped entries
// give no beats. Write base_address only while the block is idle.
module page_grouped_reloc_packer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] reloc_offset_i,
  input  logic [15:0] type_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  write_kind_o,
  output logic [19:0] byte_offset_o,
  output logic [31:0] write_value_o,
  output logic        last_o
);

  logic           push;
  pgrp_pkg::job_t push_job;
  logic           q_full;
  logic           q_valid;
  pgrp_pkg::job_t q_head;
  logic           pop;

  pgrp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .reloc_offset_i (reloc_offset_i),
    .type_bits_i    (type_bits_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .job_o          (push_job)
  );

  pgrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (pop)
  );

  pgrp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .head_i        (q_head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .write_kind_o  (write_kind_o),
    .byte_offset_o (byte_offset_o),
    .write_value_o (write_value_o),
    .last_o        (last_o)
  );

endmodule
